// ----- hdl/hist_pkg.sv -----
`default_nettype none
package hist_pkg;
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_CELLS = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic [8:0]         bin_index;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         bin;
    logic [31:0]        bin_count;
    logic [31:0]        obs_count;
    logic signed [47:0] sum_total;
    logic [63:0]        sumsq_total;
    logic signed [15:0] min_seen;
    logic signed [15:0] max_seen;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic [8:0]         bin;
    logic               bin_ok;
  } work_t;
endpackage
`default_nettype wire

// ----- hdl/hist_ram.sv -----
`default_nettype none
module hist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 258
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/hist_front.sv -----
`default_nettype none
// Bin classification: a restoring divider, one quotient bit per cycle.
module hist_front import hist_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_item_t           in_data,
  input  wire logic signed [15:0] range_lower,
  input  wire logic [15:0]        bin_width,
  input  wire logic [8:0]         cells_in_use,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output work_t                   q_data
);
  localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2;
  logic [1:0]  state_r, state_nxt;
  in_item_t    item_r;
  logic [17:0] num_r;   // 2d + w, up to 18 bits
  logic [17:0] rem_r;
  logic [17:0] quo_r;
  logic [17:0] den_r;   // 2w
  logic [4:0]  cnt_r;
  logic        below_r;
  logic [8:0]  top_r;

  logic signed [16:0] diff;
  logic [15:0]        w_eff;
  logic [8:0]         cells;
  logic [18:0]        trial;
  logic [8:0]         bin_calc;

  assign diff  = 17'(in_data.sample) - 17'(range_lower);
  assign w_eff = (bin_width == 16'd0) ? 16'd1 : bin_width;
  always_comb begin
    cells = cells_in_use;
    if (cells == 9'd0) cells = 9'd1;
    if (cells > 9'd256) cells = 9'd256;
  end
  assign trial = {rem_r, num_r[17]} - {1'b0, den_r};

  always_comb begin
    if (below_r) bin_calc = 9'd0;
    else if (quo_r >= 18'(top_r - 9'd1)) bin_calc = top_r;
    else bin_calc = quo_r[8:0] + 9'd1;
  end

  assign in_stall = (state_r != S_IDLE);
  assign q_valid  = (state_r == S_OUT);
  // clear and the unused op report bin 0
  assign q_data   = '{op: item_r.op, sample: item_r.sample,
                      bin: (item_r.op == OP_ADD) ? bin_calc :
                           ((item_r.op == OP_READ) ? item_r.bin_index : 9'd0),
                      bin_ok: (item_r.op == OP_ADD) || (item_r.bin_index < 9'd258)};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = (in_data.op == OP_ADD) ? S_DIV : S_OUT;
      S_DIV:  if (cnt_r == 5'd17) state_nxt = S_OUT;
      S_OUT:  if (q_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    if (state_r == S_IDLE && in_valid) begin
      item_r  <= in_data;
      below_r <= diff < 0;
      num_r   <= {1'b0, diff[15:0], 1'b0} + 18'(w_eff);
      den_r   <= {1'b0, w_eff, 1'b0};
      rem_r   <= '0;
      quo_r   <= '0;
      cnt_r   <= '0;
      top_r   <= cells + 9'd1;
    end else if (state_r == S_DIV) begin
      num_r <= {num_r[16:0], 1'b0};
      cnt_r <= cnt_r + 5'd1;
      if (!trial[18]) begin
        rem_r <= trial[17:0];
        quo_r <= {quo_r[16:0], 1'b1};
      end else begin
        rem_r <= {rem_r[16:0], num_r[17]};
        quo_r <= {quo_r[16:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hist_queue.sv -----
`default_nettype none
module hist_queue import hist_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire work_t wr_data,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output work_t      rd_data
);
  work_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// ----- hdl/hist_back.sv -----
`default_nettype none
// Executes add / clear / read against bin memory and running statistics.
module hist_back import hist_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire work_t q_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);
  localparam int NB = 258;
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_SQ = 3'd3,
                         S_UPD = 3'd4, S_OUT = 3'd5;
  logic [2:0]         state_r, state_nxt;
  logic [8:0]         clr_r;
  work_t              w_r;
  logic [31:0]        obs_r;
  logic signed [47:0] sum_r;
  logic [63:0]        sq_r;
  logic signed [15:0] min_r, max_r;
  logic [31:0]        sqv_r;
  logic [31:0]        cnt_r;
  logic               we;
  logic [8:0]         waddr, raddr;
  logic [31:0]        wdata, rdata;
  logic [15:0]        absv;
  logic signed [48:0] sum_w;
  logic [64:0]        sq_w;
  logic [31:0]        inc;

  hist_ram #(.WIDTH(32), .DEPTH(NB)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign absv  = w_r.sample[15] ? 16'(-w_r.sample) : w_r.sample;
  assign sum_w = 49'(sum_r) + 49'(w_r.sample);
  assign sq_w  = {1'b0, sq_r} + 65'(sqv_r);
  assign inc   = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 32'd1;
  // hold the read address on the accepted bin until the update
  assign raddr = (state_r == S_IDLE) ? q_data.bin : w_r.bin;
  assign we    = (state_r == S_CLR) || (state_r == S_UPD && w_r.op == OP_ADD);
  assign waddr = (state_r == S_CLR) ? clr_r : w_r.bin;
  assign wdata = (state_r == S_CLR) ? 32'd0 : inc;
  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{bin: w_r.bin, bin_count: cnt_r, obs_count: obs_r,
                       sum_total: sum_r, sumsq_total: sq_r,
                       min_seen: min_r, max_seen: max_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == 9'(NB - 1)) state_nxt = S_IDLE;
      S_IDLE: if (q_valid) state_nxt = (q_data.op == OP_CLEAR) ? S_CLR : S_RD;
      S_RD:   state_nxt = S_SQ;
      S_SQ:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // clear sweep reports when done
    if (state_r == S_CLR && clr_r == 9'(NB - 1) && w_r.op == OP_CLEAR) state_nxt = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      w_r.op  <= OP_ADD;
      obs_r <= '0; sum_r <= '0; sq_r <= '0; min_r <= '0; max_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 9'd1;
      if (state_r == S_IDLE && q_valid) begin
        w_r   <= q_data;
        clr_r <= '0;
        if (q_data.op == OP_CLEAR) begin
          obs_r <= '0; sum_r <= '0; sq_r <= '0; min_r <= '0; max_r <= '0;
          cnt_r <= '0;
        end
      end
      if (state_r == S_SQ) sqv_r <= absv * absv;
      if (state_r == S_UPD) begin
        if (w_r.op == OP_ADD) begin
          cnt_r <= inc;
          obs_r <= (obs_r == 32'hFFFF_FFFF) ? obs_r : obs_r + 32'd1;
          if (sum_w > 49'sh7FFF_FFFF_FFFF) sum_r <= 48'sh7FFF_FFFF_FFFF;
          else if (sum_w < -49'sh8000_0000_0000) sum_r <= 48'sh8000_0000_0000;
          else sum_r <= sum_w[47:0];
          sq_r <= sq_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_w[63:0];
          if (obs_r == 32'd0) begin
            min_r <= w_r.sample; max_r <= w_r.sample;
          end else if (w_r.sample < min_r) min_r <= w_r.sample;
          else if (w_r.sample > max_r) max_r <= w_r.sample;
        end else if (w_r.op == OP_READ) begin
          cnt_r <= w_r.bin_ok ? rdata : 32'd0;
        end else begin
          cnt_r <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/histogram_with_running_stats.sv -----
// Flow: an add passes the 18-step bin divider, then a memory read-modify-write;
//   read and unused op skip the divider; clear sweeps all 258 bin memory entries.
// Each half takes a new transaction only after handing on its current one (front:
//   through the divider; back: until out is taken); the slower half sets the rate.
// Reset (synchronous, rst_n low): registers return to lower 0, width 1, 256 cells;
//   a sweep then zeroes all 258 bin memory entries while the input still queues.
`default_nettype none
module histogram_with_running_stats import hist_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic signed [15:0] lower_r;
  logic [15:0]        width_r;
  logic [8:0]         cells_r;
  logic  fq_valid, fq_ready, bq_valid, bq_ready;
  work_t fq_data, bq_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0; width_r <= 16'd1; cells_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOWER: lower_r <= cfg_data;
        REG_WIDTH: width_r <= cfg_data;
        REG_CELLS: cells_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // front: classify, divide to find the bin
  hist_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_data,
    .range_lower(lower_r), .bin_width(width_r), .cells_in_use(cells_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

  // two-entry queue decouples the halves
  hist_queue u_queue (.clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_data(fq_data), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data));

  // back: bin memory and statistics
  hist_back u_back (.clk, .rst_n, .q_valid(bq_valid), .q_ready(bq_ready),
    .q_data(bq_data), .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire
